### hdl/plfs_pkg.sv
// plfs_pkg: shared types for the posting list frequency sort core.
// Entry layout and sequencer state encoding; no dependencies.
// Used by posting_list_frequency_sort_core.

package plfs_pkg;

    localparam int DOC_W   = 32;
    localparam int COUNT_W = 24;
    localparam int ENTRY_W = DOC_W + COUNT_W;

    // packed so that doc sits in the low bits, matching the stream tdata layout
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [DOC_W-1:0]   doc;
    } entry_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_POP,
        ST_POP_WAIT,
        ST_PIV_A,
        ST_PIV_B,
        ST_PIV_C,
        ST_SCAN,
        ST_SWAP_RD,
        ST_SWAP_WR,
        ST_FINAL_RD,
        ST_FINAL_WR,
        ST_PUSH_R,
        ST_EMIT_RD,
        ST_EMIT
    } state_t;

endpackage

### hdl/plfs_range_stack.sv
// plfs_range_stack: LIFO of pending (lo, hi) sort ranges held in a small memory.
// Registered pop data, one push or one pop per cycle.
// Standalone; instantiated by posting_list_frequency_sort_core.

module plfs_range_stack #(
    parameter int DEPTH = 64,
    parameter int IW    = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic          pop,
    input  logic [IW-1:0] push_lo,
    input  logic [IW-1:0] push_hi,
    output logic [IW-1:0] pop_lo,
    output logic [IW-1:0] pop_hi,
    output logic          empty
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [2*IW-1:0] ranges [DEPTH];
    logic [2*IW-1:0] rd_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [CW-1:0]   top_idx;

    assign top_idx = count_reg - CW'(1);
    assign empty   = (count_reg == '0);
    assign pop_lo  = rd_reg[IW-1:0];
    assign pop_hi  = rd_reg[2*IW-1:IW];

    always_comb
    begin
        count_next = count_reg;
        if (push)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop)
        begin
            count_next = top_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ranges[count_reg[IW-1:0]] <= {push_hi, push_lo};
        end
        if (pop)
        begin
            rd_reg <= ranges[top_idx[IW-1:0]];
        end
    end

`ifndef ASSERT_OFF
    a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && pop))
        else $error("range stack: push and pop in one cycle");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("range stack: pop from empty stack");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < CW'(DEPTH)))
        else $error("range stack: push onto full stack");
`endif

endmodule

### hdl/posting_list_frequency_sort_core.sv
// Posting list sort core: collects up to MAX_ENTRIES (doc, count) items, one per cycle, then
// on the item with tlast sorts them by descending count with an in-place quicksort (middle
// pivot moved to the range end, forward swap of entries >= pivot) and streams them out as
// one run, tlast on the last item, tuser set on every item if entries were dropped for lack
// of room. All entries live in one memory with one read and one write port and a registered
// read; that single write port sets the cost. A partition pops a range, parks the middle
// pivot at the range end, scans the range, swapping each entry >= pivot that must move
// forward, then places the pivot and pushes the subranges on the range stack; output
// streams one item per cycle but also waits on m_axis_tready. Input is accepted only while
// loading; the last result may still sit in the output register.
// Depends on plfs_pkg and plfs_range_stack.

module posting_list_frequency_sort_core #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // [31:0] doc_number, [55:32] term_count
    input  logic        s_axis_tlast,   // final_entry
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [31:0] sorted_doc, [55:32] sorted_count
    output logic        m_axis_tlast,   // run_end
    output logic        m_axis_tuser    // dropped_entries
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    // entry memory
    plfs_pkg::entry_t mem [MAX_ENTRIES];
    plfs_pkg::entry_t rd_reg;
    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    plfs_pkg::entry_t mem_wdata;
    logic             mem_re;
    logic [IW-1:0]    mem_raddr;

    plfs_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    total_reg, total_next;
    logic             ovf_reg, ovf_next;
    logic [IW-1:0]    lo_reg, lo_next;
    logic [IW-1:0]    hi_reg, hi_next;
    logic [IW-1:0]    i_reg, i_next;
    logic [IW-1:0]    slot_reg, slot_next;
    logic [IW-1:0]    k_reg, k_next;
    plfs_pkg::entry_t piv_reg, piv_next;
    plfs_pkg::entry_t hold_reg, hold_next;
    logic             out_valid_reg, out_valid_next;
    plfs_pkg::entry_t out_data_reg, out_data_next;
    logic             out_last_reg, out_last_next;
    logic             out_drop_reg, out_drop_next;

    // range stack
    logic          st_push;
    logic          st_pop;
    logic [IW-1:0] st_push_lo;
    logic [IW-1:0] st_push_hi;
    logic [IW-1:0] st_pop_lo;
    logic [IW-1:0] st_pop_hi;
    logic          st_empty;

    logic             in_acc;
    logic             room;
    logic [CW-1:0]    total_new;
    plfs_pkg::entry_t in_entry;
    logic [IW-1:0]    mid_pop;
    logic [IW-1:0]    mid_cur;
    logic             take;
    logic             at_end;
    logic [IW-1:0]    slot_take;
    logic             left_ok;
    logic             right_ok;
    logic             out_free;
    logic             emit_last;

    plfs_range_stack #(
        .DEPTH (MAX_ENTRIES),
        .IW    (IW)
    ) u_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (st_push),
        .pop     (st_pop),
        .push_lo (st_push_lo),
        .push_hi (st_push_hi),
        .pop_lo  (st_pop_lo),
        .pop_hi  (st_pop_hi),
        .empty   (st_empty)
    );

    assign s_axis_tready = (state_reg == plfs_pkg::ST_LOAD);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_entry      = s_axis_tdata;
    assign room          = (total_reg < CW'(MAX_ENTRIES));
    assign total_new     = room ? (total_reg + CW'(1)) : total_reg;

    assign mid_pop   = st_pop_lo + IW'((st_pop_hi - st_pop_lo) >> 1);
    assign mid_cur   = lo_reg + IW'((hi_reg - lo_reg) >> 1);
    assign take      = (rd_reg.count >= piv_reg.count);
    assign at_end    = ((i_reg + IW'(1)) == hi_reg);
    assign slot_take = take ? (slot_reg + IW'(1)) : slot_reg;
    assign left_ok   = (CW'(slot_reg) > (CW'(lo_reg) + CW'(1)));
    assign right_ok  = ((CW'(slot_reg) + CW'(1)) < CW'(hi_reg));
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign emit_last = ((CW'(k_reg) + CW'(1)) == total_reg);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_drop_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            plfs_pkg::ST_LOAD:
            begin
                if (in_acc && s_axis_tlast)
                begin
                    state_next = (total_new >= CW'(2)) ? plfs_pkg::ST_POP
                                                       : plfs_pkg::ST_EMIT_RD;
                end
            end
            plfs_pkg::ST_POP:
            begin
                state_next = st_empty ? plfs_pkg::ST_EMIT_RD : plfs_pkg::ST_POP_WAIT;
            end
            plfs_pkg::ST_POP_WAIT: state_next = plfs_pkg::ST_PIV_A;
            plfs_pkg::ST_PIV_A:    state_next = plfs_pkg::ST_PIV_B;
            plfs_pkg::ST_PIV_B:    state_next = plfs_pkg::ST_PIV_C;
            plfs_pkg::ST_PIV_C:    state_next = plfs_pkg::ST_SCAN;
            plfs_pkg::ST_SCAN:
            begin
                if (take && (slot_reg != i_reg))
                begin
                    state_next = plfs_pkg::ST_SWAP_RD;
                end
                else if (at_end)
                begin
                    state_next = plfs_pkg::ST_FINAL_RD;
                end
            end
            plfs_pkg::ST_SWAP_RD:  state_next = plfs_pkg::ST_SWAP_WR;
            plfs_pkg::ST_SWAP_WR:
            begin
                state_next = at_end ? plfs_pkg::ST_FINAL_RD : plfs_pkg::ST_SCAN;
            end
            plfs_pkg::ST_FINAL_RD: state_next = plfs_pkg::ST_FINAL_WR;
            plfs_pkg::ST_FINAL_WR: state_next = plfs_pkg::ST_PUSH_R;
            plfs_pkg::ST_PUSH_R:   state_next = plfs_pkg::ST_POP;
            plfs_pkg::ST_EMIT_RD:  state_next = plfs_pkg::ST_EMIT;
            plfs_pkg::ST_EMIT:
            begin
                if (out_free && emit_last)
                begin
                    state_next = plfs_pkg::ST_LOAD;
                end
            end
            default:               state_next = plfs_pkg::ST_LOAD;
        endcase
    end

    // datapath controls and register updates
    always_comb
    begin
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = in_entry;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        st_push        = 1'b0;
        st_pop         = 1'b0;
        st_push_lo     = lo_reg;
        st_push_hi     = hi_reg;
        total_next     = total_reg;
        ovf_next       = ovf_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        i_next         = i_reg;
        slot_next      = slot_reg;
        k_next         = k_reg;
        piv_next       = piv_reg;
        hold_next      = hold_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_drop_next  = out_drop_reg;

        case (state_reg)
            plfs_pkg::ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (room)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = total_reg[IW-1:0];
                        total_next = total_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_axis_tlast && (total_new >= CW'(2)))
                    begin
                        st_push    = 1'b1;
                        st_push_lo = '0;
                        st_push_hi = IW'(total_new - CW'(1));
                    end
                end
            end
            plfs_pkg::ST_POP:
            begin
                st_pop = !st_empty;
            end
            plfs_pkg::ST_POP_WAIT:
            begin
                lo_next   = st_pop_lo;
                hi_next   = st_pop_hi;
                mem_re    = 1'b1;
                mem_raddr = mid_pop;
            end
            plfs_pkg::ST_PIV_A:
            begin
                piv_next  = rd_reg;
                mem_re    = 1'b1;
                mem_raddr = hi_reg;
            end
            plfs_pkg::ST_PIV_B:
            begin
                mem_we    = 1'b1;
                mem_waddr = mid_cur;
                mem_wdata = rd_reg;
            end
            plfs_pkg::ST_PIV_C:
            begin
                mem_we    = 1'b1;
                mem_waddr = hi_reg;
                mem_wdata = piv_reg;
                mem_re    = 1'b1;
                mem_raddr = lo_reg;
                i_next    = lo_reg;
                slot_next = lo_reg;
            end
            plfs_pkg::ST_SCAN:
            begin
                mem_re = 1'b1;
                if (take && (slot_reg != i_reg))
                begin
                    hold_next = rd_reg;
                    mem_raddr = slot_reg;
                end
                else
                begin
                    slot_next = slot_take;
                    if (at_end)
                    begin
                        mem_raddr = slot_take;
                    end
                    else
                    begin
                        i_next    = i_reg + IW'(1);
                        mem_raddr = i_reg + IW'(1);
                    end
                end
            end
            plfs_pkg::ST_SWAP_RD:
            begin
                mem_we    = 1'b1;
                mem_waddr = slot_reg;
                mem_wdata = hold_reg;
                hold_next = rd_reg;
            end
            plfs_pkg::ST_SWAP_WR:
            begin
                // read may hit the entry written here; the memory forwards it
                mem_we    = 1'b1;
                mem_waddr = i_reg;
                mem_wdata = hold_reg;
                slot_next = slot_reg + IW'(1);
                mem_re    = 1'b1;
                if (at_end)
                begin
                    mem_raddr = slot_reg + IW'(1);
                end
                else
                begin
                    i_next    = i_reg + IW'(1);
                    mem_raddr = i_reg + IW'(1);
                end
            end
            plfs_pkg::ST_FINAL_RD:
            begin
                mem_we    = 1'b1;
                mem_waddr = slot_reg;
                mem_wdata = piv_reg;
                hold_next = rd_reg;
            end
            plfs_pkg::ST_FINAL_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = hi_reg;
                mem_wdata  = hold_reg;
                st_push    = left_ok;
                st_push_lo = lo_reg;
                st_push_hi = slot_reg - IW'(1);
            end
            plfs_pkg::ST_PUSH_R:
            begin
                st_push    = right_ok;
                st_push_lo = slot_reg + IW'(1);
                st_push_hi = hi_reg;
            end
            plfs_pkg::ST_EMIT_RD:
            begin
                k_next    = '0;
                mem_re    = 1'b1;
                mem_raddr = '0;
            end
            plfs_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = rd_reg;
                    out_last_next  = emit_last;
                    out_drop_next  = ovf_reg;
                    if (emit_last)
                    begin
                        total_next = '0;
                        ovf_next   = 1'b0;
                    end
                    else
                    begin
                        k_next    = k_reg + IW'(1);
                        mem_re    = 1'b1;
                        mem_raddr = k_reg + IW'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= plfs_pkg::ST_LOAD;
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        i_reg        <= i_next;
        slot_reg     <= slot_next;
        k_reg        <= k_next;
        piv_reg      <= piv_next;
        hold_reg     <= hold_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_drop_reg <= out_drop_next;
    end

    // entry memory with write-to-read forwarding on the same address
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_reg <= (mem_we && (mem_waddr == mem_raddr)) ? mem_wdata : mem[mem_raddr];
        end
    end

`ifndef ASSERT_OFF
    a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == plfs_pkg::ST_SCAN) |-> ((slot_reg <= i_reg) && (i_reg < hi_reg)))
        else $error("scan indexes out of order");

    a_final_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == plfs_pkg::ST_FINAL_RD) |-> ((slot_reg <= hi_reg) && (lo_reg <= slot_reg)))
        else $error("pivot slot outside range");

    a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CW'(MAX_ENTRIES))
        else $error("entry count beyond capacity");
`endif

endmodule

### sim/posting_list_frequency_sort_core_tb.sv
// Testbench for posting_list_frequency_sort_core: streams posting lists in, predicts each
// sorted run with a scoreboard class (same middle-pivot quicksort) and checks every item out.
// Depends on plfs_pkg and the core RTL.
`timescale 1ns / 1ps

module posting_list_frequency_sort_core_tb;

    localparam int CAPACITY      = 64;
    localparam int QUIET_LIMIT   = 100000;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_ITEMS  = 230;

    typedef enum int
    {
        CNT_RANDOM,
        CNT_TIES,
        CNT_EXTREME,
        CNT_RISING,
        CNT_FALLING
    } count_mode_t;

    typedef struct
    {
        logic [plfs_pkg::DOC_W-1:0]   doc;
        logic [plfs_pkg::COUNT_W-1:0] count;
        logic                         run_end;
        logic                         dropped;
    } sorted_item_t;

    class sort_scoreboard;
        plfs_pkg::entry_t held_entries[$];
        bit               overflow_seen;
        sorted_item_t     expected_run[$];
        int               mismatches;
        int               capacity;

        function new(int cap);
            capacity      = cap;
            overflow_seen = 0;
            mismatches    = 0;
        endfunction

        function int pending();
            return expected_run.size();
        endfunction

        function void swap_slots(int a, int b);
            plfs_pkg::entry_t t;
            t               = held_entries[a];
            held_entries[a] = held_entries[b];
            held_entries[b] = t;
        endfunction

        // pivot from the middle, parked at hi; entries >= pivot move forward in scan order
        function int split_range(int lo, int hi);
            int                           slot;
            logic [plfs_pkg::COUNT_W-1:0] pivot;
            pivot = held_entries[lo + (hi - lo) / 2].count;
            swap_slots(lo + (hi - lo) / 2, hi);
            slot = lo;
            for (int i = lo; i < hi; i++)
            begin
                if (held_entries[i].count >= pivot)
                begin
                    swap_slots(slot, i);
                    slot++;
                end
            end
            swap_slots(slot, hi);
            return slot;
        endfunction

        function void sort_held();
            int lo_stack[$];
            int hi_stack[$];
            int lo;
            int hi;
            int q;
            if (held_entries.size() >= 2)
            begin
                lo_stack.insert(lo_stack.size(), 0);
                hi_stack.insert(hi_stack.size(), held_entries.size() - 1);
            end
            while (lo_stack.size() > 0)
            begin
                lo = lo_stack.pop_back();
                hi = hi_stack.pop_back();
                if (lo < hi)
                begin
                    q = split_range(lo, hi);
                    if (q > lo + 1)
                    begin
                        lo_stack.insert(lo_stack.size(), lo);
                        hi_stack.insert(hi_stack.size(), q - 1);
                    end
                    if (q + 1 < hi)
                    begin
                        lo_stack.insert(lo_stack.size(), q + 1);
                        hi_stack.insert(hi_stack.size(), hi);
                    end
                end
            end
        endfunction

        function void note_input(logic [plfs_pkg::DOC_W-1:0] doc,
                                 logic [plfs_pkg::COUNT_W-1:0] count, logic last);
            plfs_pkg::entry_t e;
            sorted_item_t     r;
            e.doc   = doc;
            e.count = count;
            if (held_entries.size() < capacity)
                held_entries.insert(held_entries.size(), e);
            else
                overflow_seen = 1;
            if (last)
            begin
                sort_held();
                foreach (held_entries[k])
                begin
                    r.doc     = held_entries[k].doc;
                    r.count   = held_entries[k].count;
                    r.run_end = (k == held_entries.size() - 1);
                    r.dropped = overflow_seen;
                    expected_run.insert(expected_run.size(), r);
                end
                held_entries.delete();
                overflow_seen = 0;
            end
        endfunction

        function void check_result(logic [plfs_pkg::DOC_W-1:0] doc,
                                   logic [plfs_pkg::COUNT_W-1:0] count,
                                   logic run_end, logic dropped);
            sorted_item_t e;
            if (expected_run.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: doc %h count %h last %b user %b",
                             doc, count, run_end, dropped);
                return;
            end
            e = expected_run.pop_front();
            if (doc !== e.doc || count !== e.count || run_end !== e.run_end
                || dropped !== e.dropped)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("bad item: expected doc %h count %h last %b user %b, got %h %h %b %b",
                             e.doc, e.count, e.run_end, e.dropped, doc, count, run_end, dropped);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [55:0]         s_axis_tdata;
    logic                s_axis_tlast;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [55:0]         m_axis_tdata;
    logic                m_axis_tlast;
    logic                m_axis_tuser;

    sort_scoreboard      sb;
    bit                  idle_on;
    int                  items_sent;
    int                  quiet_cycles;

    posting_list_frequency_sort_core #(
        .MAX_ENTRIES (CAPACITY)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic send_item(logic [plfs_pkg::DOC_W-1:0] doc,
                             logic [plfs_pkg::COUNT_W-1:0] count, logic last);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {count, doc};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        sb.note_input(doc, count, last);
        items_sent++;
    endtask

    task automatic send_list(int len, count_mode_t mode);
        logic [31:0]                  base;
        logic [31:0]                  rnd;
        logic [plfs_pkg::COUNT_W-1:0] c;
        base = $urandom_range(0, 1000);
        for (int i = 0; i < len; i++)
        begin
            case (mode)
                CNT_TIES:    rnd = $urandom_range(0, 3);
                CNT_EXTREME: rnd = $urandom_range(0, 1) ? 32'h00FFFFFF : 32'h0;
                CNT_RISING:  rnd = base + 32'(i);
                CNT_FALLING: rnd = 32'h00FFFFFF - base - 32'(i);
                default:     rnd = $urandom;
            endcase
            c = rnd[plfs_pkg::COUNT_W-1:0];
            send_item($urandom, c, i == len - 1);
        end
    endtask

    // sink side: check accepted items, stall in random bursts
    initial
    begin
        int stall_left;
        bit next_ready;
        stall_left = 0;
        m_axis_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata[31:0], m_axis_tdata[55:32],
                                m_axis_tlast, m_axis_tuser);
            if (stall_left > 0)
            begin
                stall_left--;
                next_ready = (stall_left == 0);
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 11);
                next_ready = 0;
            end
            else
                next_ready = 1;
            m_axis_tready <= next_ready;
        end
    end

    // the limit sits far above the longest sort of a full list
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("posting_list_frequency_sort_core: mismatch");
            $finish;
        end
    end

    initial
    begin
        sb            = new(CAPACITY);
        idle_on       = 1;
        items_sent    = 0;
        quiet_cycles  = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-entry lists at both extremes
        send_item(32'h0, 24'h0, 1'b1);
        send_item(32'hFFFFFFFF, 24'hFFFFFF, 1'b1);
        // tie of two
        send_item(32'h1, 24'h5, 1'b0);
        send_item(32'h2, 24'h5, 1'b1);
        // already ascending: reversal needed
        for (int i = 0; i < 5; i++)
            send_item(32'h100 + i, 24'(i), i == 4);
        // descending, including max and zero
        send_item(32'hA5A5A5A5, 24'hFFFFFF, 1'b0);
        send_item(32'h5A5A5A5A, 24'hFFFFFE, 1'b0);
        send_item(32'h80000000, 24'h800000, 1'b0);
        send_item(32'h7FFFFFFF, 24'h000001, 1'b0);
        send_item(32'h00000001, 24'h000000, 1'b1);
        // mixed ties, tie order follows the partition scheme
        send_item(32'h10, 24'h3, 1'b0);
        send_item(32'h11, 24'h7, 1'b0);
        send_item(32'h12, 24'h3, 1'b0);
        send_item(32'h13, 24'h7, 1'b0);
        send_item(32'h14, 24'h3, 1'b0);
        send_item(32'h15, 24'h0, 1'b1);

        // one full list, then one that overflows (its final item is dropped too)
        send_list(CAPACITY, count_mode_t'($urandom_range(0, 4)));
        send_list($urandom_range(CAPACITY + 1, CAPACITY + 6), CNT_RANDOM);
        while (items_sent < RANDOM_ITEMS)
        begin
            idle_on = (items_sent < RANDOM_ITEMS - 40) && ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 7) == 0)
                send_list($urandom_range(13, 40), count_mode_t'($urandom_range(0, 4)));
            else
                send_list($urandom_range(1, 12), count_mode_t'($urandom_range(0, 4)));
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("posting_list_frequency_sort_core: match");
        else
            $display("posting_list_frequency_sort_core: mismatch");
        $finish;
    end

endmodule
